/* src/brf_pkg.sv */
package brf_pkg;

  localparam int CAP_W      = 11;
  localparam int CAP_RESET  = 1024;
  localparam int BYTE_W     = 8;
  localparam int RDMAX_W    = 7;
  localparam int CNT_W      = 10;
  localparam int TOT_W      = 32;
  localparam int BURST_SAT  = 1023;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [0:0] {
    S_IDLE,
    S_READ
  } brf_state_t;

  typedef struct packed {
    logic wr;
    logic rd_empty;
    logic rd_start;
    logic rd_byte;
  } brf_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic rem_last;
    logic out_free;
  } brf_status_t;

endpackage

/* src/brf_if.sv */
interface brf_req_if;
  import brf_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [BYTE_W-1:0]  wr_byte;
  logic               wr_last;
  logic [RDMAX_W-1:0] rd_max;

  modport source (output valid, req_type, wr_byte, wr_last, rd_max, input ready);
  modport sink   (input valid, req_type, wr_byte, wr_last, rd_max, output ready);
endinterface

interface brf_resp_if;
  import brf_pkg::*;
  logic              valid;
  logic              ready;
  logic              resp_kind;
  logic [BYTE_W-1:0] rd_byte;
  logic              rd_last;
  logic [CNT_W-1:0]  xfer_count;
  logic [CNT_W-1:0]  used_bytes;
  logic [CNT_W-1:0]  free_bytes;
  logic              is_full;
  logic [TOT_W-1:0]  total_written;
  logic [TOT_W-1:0]  total_read;

  modport source (output valid, resp_kind, rd_byte, rd_last, xfer_count, used_bytes,
                  free_bytes, is_full, total_written, total_read, input ready);
  modport sink   (input valid, resp_kind, rd_byte, rd_last, xfer_count, used_bytes,
                  free_bytes, is_full, total_written, total_read, output ready);
endinterface

interface brf_cfg_if;
  import brf_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* src/brf_ctrl.sv */
module brf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 req_type,
  input  brf_pkg::brf_status_t sts,
  output logic                 in_ready,
  output brf_pkg::brf_cmd_t    cmd,
  output brf_pkg::brf_state_t  state
);
  import brf_pkg::*;

  brf_state_t state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE) && sts.out_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && req_type == REQ_READ && !sts.n_zero) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (sts.out_free && sts.rem_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_WRITE) begin
            cmd.wr = 1'b1;
          end else if (sts.n_zero) begin
            cmd.rd_empty = 1'b1;
          end else begin
            cmd.rd_start = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.rd_byte = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* src/brf_datapath.sv */
module brf_datapath #(
  parameter int BUF_DEPTH      = 1024,
  parameter int MAX_READ_BURST = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  brf_pkg::brf_cmd_t             cmd,
  output brf_pkg::brf_status_t          sts,
  input  logic                          cfg_wr,
  input  logic [brf_pkg::CAP_W-1:0]     cfg_data,
  input  logic [brf_pkg::BYTE_W-1:0]    wr_byte,
  input  logic                          wr_last,
  input  logic [brf_pkg::RDMAX_W-1:0]   rd_max,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          resp_kind,
  output logic [brf_pkg::BYTE_W-1:0]    rd_byte,
  output logic                          rd_last,
  output logic [brf_pkg::CNT_W-1:0]     xfer_count,
  output logic [brf_pkg::CNT_W-1:0]     used_bytes,
  output logic [brf_pkg::CNT_W-1:0]     free_bytes,
  output logic                          is_full,
  output logic [brf_pkg::TOT_W-1:0]     total_written,
  output logic [brf_pkg::TOT_W-1:0]     total_read
);
  import brf_pkg::*;

  localparam int AW = (BUF_DEPTH > 2) ? $clog2(BUF_DEPTH) : 1;

  function automatic logic [AW-1:0] cap_last(input logic [CAP_W-1:0] c);
    int v;
    v = int'(c);
    if (v < 2) v = 2;
    if (v > BUF_DEPTH) v = BUF_DEPTH;
    return AW'(v - 1);
  endfunction

  logic [BYTE_W-1:0] mem [BUF_DEPTH];
  logic [BYTE_W-1:0] rd_q;

  logic [AW-1:0]      wr_idx, wr_idx_next;
  logic [AW-1:0]      rd_idx, rd_idx_next;
  logic [AW-1:0]      used, used_next;
  logic [AW-1:0]      cap_m1, cap_m1_next;
  logic [CNT_W-1:0]   burst, burst_next, burst_inc;
  logic [TOT_W-1:0]   tot_w, tot_w_next;
  logic [TOT_W-1:0]   tot_r, tot_r_next;
  logic [RDMAX_W-1:0] rem, rem_next;
  logic [RDMAX_W-1:0] cnt, cnt_next;
  logic [RDMAX_W-1:0] n_lim, n_sel;
  logic               has_room;

  logic               o_load, o_kind_n, o_has_n, o_last_n;
  logic [CNT_W-1:0]   o_count_n;
  logic               o_has_byte;

  assign has_room = (used != cap_m1);
  assign burst_inc = (burst == CNT_W'(BURST_SAT)) ? burst : burst + 1'b1;

  always_comb begin
    n_lim = (int'(rd_max) > MAX_READ_BURST) ? RDMAX_W'(MAX_READ_BURST) : rd_max;
    n_sel = (int'(used) < int'(n_lim)) ? RDMAX_W'(used) : n_lim;
  end

  assign sts.n_zero   = (n_sel == '0);
  assign sts.rem_last = (rem == RDMAX_W'(1));
  assign sts.out_free = !out_valid || out_ready;

  always_comb begin
    wr_idx_next = wr_idx;
    rd_idx_next = rd_idx;
    used_next   = used;
    cap_m1_next = cap_m1;
    burst_next  = burst;
    tot_w_next  = tot_w;
    tot_r_next  = tot_r;
    rem_next    = rem;
    cnt_next    = cnt;
    o_load      = 1'b0;
    o_kind_n    = KIND_WRITE;
    o_has_n     = 1'b0;
    o_last_n    = 1'b1;
    o_count_n   = '0;
    if (cfg_wr) begin
      cap_m1_next = cap_last(cfg_data);
      wr_idx_next = '0;
      rd_idx_next = '0;
      used_next   = '0;
      burst_next  = '0;
    end else if (cmd.wr) begin
      if (has_room) begin
        wr_idx_next = (wr_idx == cap_m1) ? '0 : wr_idx + 1'b1;
        used_next   = used + 1'b1;
        tot_w_next  = tot_w + 1'b1;
        burst_next  = burst_inc;
      end
      if (wr_last) begin
        o_load     = 1'b1;
        o_count_n  = burst_next;
        burst_next = '0;
      end
    end else if (cmd.rd_empty) begin
      o_load   = 1'b1;
      o_kind_n = KIND_READ;
    end else if (cmd.rd_start) begin
      rem_next = n_sel;
      cnt_next = '0;
    end else if (cmd.rd_byte) begin
      rd_idx_next = (rd_idx == cap_m1) ? '0 : rd_idx + 1'b1;
      used_next   = used - 1'b1;
      tot_r_next  = tot_r + 1'b1;
      cnt_next    = cnt + 1'b1;
      rem_next    = rem - 1'b1;
      o_load      = 1'b1;
      o_kind_n    = KIND_READ;
      o_has_n     = 1'b1;
      o_last_n    = (rem == RDMAX_W'(1));
      o_count_n   = CNT_W'(cnt_next);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && has_room && !cfg_wr) begin
      mem[wr_idx] <= wr_byte;
    end
    if (cmd.rd_byte && !cfg_wr) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx    <= '0;
      rd_idx    <= '0;
      used      <= '0;
      cap_m1    <= cap_last(CAP_W'(CAP_RESET));
      burst     <= '0;
      tot_w     <= '0;
      tot_r     <= '0;
      rem       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      wr_idx    <= wr_idx_next;
      rd_idx    <= rd_idx_next;
      used      <= used_next;
      cap_m1    <= cap_m1_next;
      burst     <= burst_next;
      tot_w     <= tot_w_next;
      tot_r     <= tot_r_next;
      rem       <= rem_next;
      cnt       <= cnt_next;
      out_valid <= o_load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      resp_kind     <= o_kind_n;
      o_has_byte    <= o_has_n;
      rd_last       <= o_last_n;
      xfer_count    <= o_count_n;
      used_bytes    <= CNT_W'(used_next);
      free_bytes    <= CNT_W'(cap_m1 - used_next);
      is_full       <= (used_next == cap_m1);
      total_written <= tot_w_next;
      total_read    <= tot_r_next;
    end
  end

  assign rd_byte = o_has_byte ? rd_q : '0;

endmodule

/* src/byte_ring_fifo.sv */
// Byte FIFO on a circular store of BUF_DEPTH bytes, of which the capacity
// register selects how many slots are in use (one slot always stays empty).
// Channels: req (sink) carries write bytes and read requests, resp (source)
// carries results, cfg (sink) writes the capacity; a write empties the FIFO
// and keeps the running totals.
// Write bytes are taken one per cycle while req.ready is high; a byte that
// finds no room is dropped. The byte with wr_last gives one result on resp in
// the cycle after accept. A read request enters the state register; each byte
// then passes the registered store read and the result register, one per
// cycle while resp takes them, with req.ready low for the whole read. A read
// with no bytes to give (FIFO empty or rd_max zero) gives one result of count
// zero in the cycle after accept. When resp stalls, the result register holds
// and req.ready stays low until the result is taken. Reset empties the FIFO,
// clears the totals, sets the capacity to 1024; store contents are not cleared.
module byte_ring_fifo #(
  parameter int BUF_DEPTH      = 1024,
  parameter int MAX_READ_BURST = 64
) (
  input logic        clk,
  input logic        rst,
  brf_req_if.sink    req,
  brf_resp_if.source resp,
  brf_cfg_if.sink    cfg
);
  import brf_pkg::*;

  brf_cmd_t    cmd;
  brf_status_t sts;
  brf_state_t  state;
  logic        cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .req_type (req.req_type),
    .sts      (sts),
    .in_ready (req.ready),
    .cmd      (cmd),
    .state    (state)
  );

  brf_datapath #(
    .BUF_DEPTH      (BUF_DEPTH),
    .MAX_READ_BURST (MAX_READ_BURST)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_wr        (cfg_wr),
    .cfg_data      (cfg.data),
    .wr_byte       (req.wr_byte),
    .wr_last       (req.wr_last),
    .rd_max        (req.rd_max),
    .out_valid     (resp.valid),
    .out_ready     (resp.ready),
    .resp_kind     (resp.resp_kind),
    .rd_byte       (resp.rd_byte),
    .rd_last       (resp.rd_last),
    .xfer_count    (resp.xfer_count),
    .used_bytes    (resp.used_bytes),
    .free_bytes    (resp.free_bytes),
    .is_full       (resp.is_full),
    .total_written (resp.total_written),
    .total_read    (resp.total_read)
  );

  a_read_enters: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.req_type == REQ_READ && !sts.n_zero)
      |=> (state == S_READ))
    else $error("read request with data did not start a read burst");

  a_no_req_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !req.ready)
    else $error("request taken during a read burst");

  a_write_result: assert property (@(posedge clk) disable iff (rst)
    (resp.valid && resp.resp_kind == KIND_WRITE) |-> (resp.rd_last && resp.rd_byte == '0))
    else $error("write result without last mark or with a data byte");

  a_burst_output: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_byte |=> (resp.valid && resp.resp_kind == KIND_READ && resp.xfer_count != '0))
    else $error("read byte issued without a read result");

endmodule
